FILE: src/tmv_pkg.sv
// tmv_pkg: shared constants for the trimmed-mean voltage filter.
// Group length, datapath widths and reciprocal constants for the two
// constant divisions. No dependencies.
package tmv_pkg;

  // Group length and sample counter
  localparam int unsigned SAMPLE_COUNT = 10;
  localparam int unsigned CNT_W        = 6;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLE_COUNT - 1);

  // Field widths
  localparam int unsigned SMP_W = 12;
  localparam int unsigned MV_W  = 16;
  localparam int unsigned SUM_W = 18;

  localparam logic [SMP_W-1:0] CODE_MAX = {SMP_W{1'b1}};
  localparam logic [MV_W-1:0]  MV_MAX   = {MV_W{1'b1}};
  localparam logic [MV_W-1:0]  FULL_SCALE_MV_RESET = 16'd13200;

  // Mean: trimmed sum / (SAMPLE_COUNT - 2) by reciprocal, one correction step
  localparam int unsigned DEN_W      = 6;
  localparam logic [DEN_W-1:0] DIV_DEN = DEN_W'(SAMPLE_COUNT - 2);
  localparam int unsigned DIV_SHIFT  = SUM_W;
  localparam int unsigned DIV_MULT_W = SUM_W + 1;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'((64'd1 << DIV_SHIFT) / (SAMPLE_COUNT - 2));
  localparam int unsigned DIV_PROD_W = SUM_W + DIV_MULT_W;
  localparam int unsigned DIV_Q_W    = DIV_PROD_W - DIV_SHIFT;
  localparam int unsigned DIV_R_W    = DIV_Q_W + DEN_W;

  // Scale: (code * full_scale) / 4095 by reciprocal, one correction step
  localparam int unsigned SCL_P_W    = SMP_W + MV_W;
  localparam int unsigned SCL_DEN_W  = 12;
  localparam logic [SCL_DEN_W-1:0] SCL_DEN = 12'd4095;
  localparam int unsigned SCL_SHIFT  = SCL_P_W;
  localparam int unsigned SCL_MULT_W = 17;
  localparam logic [SCL_MULT_W-1:0] SCL_MULT =
    SCL_MULT_W'((64'd1 << SCL_SHIFT) / 4095);
  localparam int unsigned SCL_PROD_W = SCL_P_W + SCL_MULT_W;
  localparam int unsigned SCL_Q_W    = SCL_PROD_W - SCL_SHIFT;
  localparam int unsigned SCL_R_W    = SCL_Q_W + SCL_DEN_W;

endpackage

FILE: src/trimmed_mean_voltage.sv
// trimmed_mean_voltage: trimmed-mean filter over groups of converter samples.
// Uses tmv_pkg for group length, widths and reciprocal constants.
// Throughput: one sample per cycle, busy_o never rises; results are never stalled.
// done_o follows a group's last sample through the trim, mean and scale registers.
// Pipeline: input reg, accumulate/trim, two multiply+correct divisions, output reg.
// Reset: group state cleared, full scale set to 13200 mV, no result in flight.
module trimmed_mean_voltage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [tmv_pkg::SMP_W-1:0] sample_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tmv_pkg::MV_W-1:0]  cfg_data_i,
  output logic                      done_o,
  output logic [tmv_pkg::SMP_W-1:0] average_code_o,
  output logic [tmv_pkg::MV_W-1:0]  millivolts_o
);

  // Handshake: samples and config beats are always taken
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic                      in_beat;
  assign in_beat = start_i & ~busy_o;

  // Control registers
  logic [tmv_pkg::MV_W-1:0]  fs_q;
  logic                      smp_vld_q, trim_vld_q, qp_vld_q, avg_vld_q, mp_vld_q, mq_vld_q;
  logic                      done_q;
  logic [tmv_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [tmv_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [tmv_pkg::SMP_W-1:0] min_q, min_d, max_q, max_d;

  // Payload registers
  logic [tmv_pkg::SMP_W-1:0]      smp_q;
  logic [tmv_pkg::SUM_W-1:0]      trim_q, trim_d, trim2_q;
  logic [tmv_pkg::DIV_PROD_W-1:0] qprod_q, qprod_d;
  logic [tmv_pkg::SMP_W-1:0]      avg_q, avg_d, avg4_q, avg5_q;
  logic [tmv_pkg::SCL_P_W-1:0]    mprod_q, mprod_d, mprod5_q;
  logic [tmv_pkg::SCL_PROD_W-1:0] mqprod_q, mqprod_d;
  logic [tmv_pkg::SMP_W-1:0]      out_avg_q;
  logic [tmv_pkg::MV_W-1:0]       out_mv_q, mv_d;

  // Accumulate, track extremes and trim on the last sample of a group
  logic [tmv_pkg::SUM_W-1:0] sum_new;
  logic [tmv_pkg::SMP_W-1:0] min_new, max_new;
  logic                      last_smp;
  always_comb begin
    sum_new  = sum_q + tmv_pkg::SUM_W'(smp_q);
    min_new  = (smp_q < min_q) ? smp_q : min_q;
    max_new  = (smp_q > max_q) ? smp_q : max_q;
    last_smp = smp_vld_q && (cnt_q == tmv_pkg::LAST_CNT);
    trim_d   = sum_new - tmv_pkg::SUM_W'(min_new) - tmv_pkg::SUM_W'(max_new);
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    min_d    = min_q;
    max_d    = max_q;
    if (last_smp) begin
      cnt_d = '0;
      sum_d = '0;
      min_d = tmv_pkg::CODE_MAX;
      max_d = '0;
    end else if (smp_vld_q) begin
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_new;
      min_d = min_new;
      max_d = max_new;
    end
  end

  // Mean: reciprocal product
  assign qprod_d = tmv_pkg::DIV_PROD_W'(trim_q) * tmv_pkg::DIV_PROD_W'(tmv_pkg::DIV_MULT);

  // Mean: quotient estimate is exact or one low; fix with one compare
  logic [tmv_pkg::DIV_Q_W-1:0] q_est, q_fix;
  logic [tmv_pkg::DIV_R_W-1:0] q_rem;
  always_comb begin
    q_est = qprod_q[tmv_pkg::DIV_PROD_W-1:tmv_pkg::DIV_SHIFT];
    q_rem = tmv_pkg::DIV_R_W'(trim2_q)
          - tmv_pkg::DIV_R_W'(q_est) * tmv_pkg::DIV_R_W'(tmv_pkg::DIV_DEN);
    q_fix = q_est;
    if (q_rem >= tmv_pkg::DIV_R_W'(tmv_pkg::DIV_DEN)) q_fix = q_est + 1'b1;
    if (q_fix > tmv_pkg::DIV_Q_W'(tmv_pkg::CODE_MAX)) avg_d = tmv_pkg::CODE_MAX;
    else avg_d = q_fix[tmv_pkg::SMP_W-1:0];
  end

  // Scale: code times full scale, then reciprocal of 4095
  assign mprod_d  = tmv_pkg::SCL_P_W'(avg_q) * tmv_pkg::SCL_P_W'(fs_q);
  assign mqprod_d = tmv_pkg::SCL_PROD_W'(mprod_q)
                  * tmv_pkg::SCL_PROD_W'(tmv_pkg::SCL_MULT);

  logic [tmv_pkg::SCL_Q_W-1:0] m_est, m_fix;
  logic [tmv_pkg::SCL_R_W-1:0] m_rem;
  always_comb begin
    m_est = mqprod_q[tmv_pkg::SCL_PROD_W-1:tmv_pkg::SCL_SHIFT];
    m_rem = tmv_pkg::SCL_R_W'(mprod5_q)
          - tmv_pkg::SCL_R_W'(m_est) * tmv_pkg::SCL_R_W'(tmv_pkg::SCL_DEN);
    m_fix = m_est;
    if (m_rem >= tmv_pkg::SCL_R_W'(tmv_pkg::SCL_DEN)) m_fix = m_est + 1'b1;
    if (m_fix > tmv_pkg::SCL_Q_W'(tmv_pkg::MV_MAX)) mv_d = tmv_pkg::MV_MAX;
    else mv_d = m_fix[tmv_pkg::MV_W-1:0];
  end

  // Control state: config, group state, valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q       <= tmv_pkg::FULL_SCALE_MV_RESET;
      cnt_q      <= '0;
      sum_q      <= '0;
      min_q      <= tmv_pkg::CODE_MAX;
      max_q      <= '0;
      smp_vld_q  <= 1'b0;
      trim_vld_q <= 1'b0;
      qp_vld_q   <= 1'b0;
      avg_vld_q  <= 1'b0;
      mp_vld_q   <= 1'b0;
      mq_vld_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) fs_q <= cfg_data_i;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      min_q      <= min_d;
      max_q      <= max_d;
      smp_vld_q  <= in_beat;
      trim_vld_q <= last_smp;
      qp_vld_q   <= trim_vld_q;
      avg_vld_q  <= qp_vld_q;
      mp_vld_q   <= avg_vld_q;
      mq_vld_q   <= mp_vld_q;
      done_q     <= mq_vld_q;
    end
  end

  // Payload pipeline, no reset
  always_ff @(posedge clk_i) begin
    if (in_beat) smp_q <= sample_i;
    trim_q    <= trim_d;
    qprod_q   <= qprod_d;
    trim2_q   <= trim_q;
    avg_q     <= avg_d;
    mprod_q   <= mprod_d;
    avg4_q    <= avg_q;
    mqprod_q  <= mqprod_d;
    mprod5_q  <= mprod_q;
    avg5_q    <= avg4_q;
    out_avg_q <= avg5_q;
    out_mv_q  <= mv_d;
  end

  assign done_o         = done_q;
  assign average_code_o = out_avg_q;
  assign millivolts_o   = out_mv_q;

endmodule
